[design/assert_macros.svh]
// Assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/npfe_pkg.sv]
package npfe_pkg;

    localparam int LINE_PIXELS_DEF = 512;
    localparam int LINES_DEF       = 256;

    localparam logic [3:0] NIBBLES_PER_PACKET = 4'd14;
    localparam logic [3:0] LAST_NIBBLE        = 4'd13;

    localparam logic [9:0] ACTIVE_WIDTH_RST  = 10'd320;
    localparam logic [8:0] ACTIVE_HEIGHT_RST = 9'd240;

    // Packet types
    localparam logic [7:0] PKT_BLANK = 8'd0;
    localparam logic [7:0] PKT_PIXEL = 8'd1;
    localparam logic [7:0] PKT_RED   = 8'd2;
    localparam logic [7:0] PKT_GREEN = 8'd3;
    localparam logic [7:0] PKT_BLUE  = 8'd4;
    localparam logic [7:0] PKT_WHITE = 8'd5;
    localparam logic [7:0] PKT_FILL  = 8'd6;

    localparam logic [15:0] COLOUR_BLACK = 16'h0000;
    localparam logic [15:0] COLOUR_RED   = 16'hF800;
    localparam logic [15:0] COLOUR_GREEN = 16'h07E0;
    localparam logic [15:0] COLOUR_BLUE  = 16'h001F;
    localparam logic [15:0] COLOUR_WHITE = 16'hFFFF;

    typedef enum logic [2:0] {
        OUT_NONE    = 3'd0,
        OUT_BLANKED = 3'd1,
        OUT_WRITTEN = 3'd2,
        OUT_RANGE   = 3'd3,
        OUT_FILLED  = 3'd4,
        OUT_UNKNOWN = 3'd5
    } outcome_t;

    // Register indexes on the configuration port
    localparam logic REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic REG_ACTIVE_HEIGHT = 1'b1;

endpackage

[design/npfe_if.sv]
interface npfe_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [3:0] nibble;
    logic [8:0] read_x;
    logic [7:0] read_y;

    modport source (output valid, action, nibble, read_x, read_y, input ready);
    modport sink (input valid, action, nibble, read_x, read_y, output ready);
endinterface

interface npfe_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_index;
    logic        packet_done;
    logic [2:0]  outcome;
    logic [15:0] pixel_value;

    modport source (output valid, byte_index, packet_done, outcome, pixel_value, input ready);
    modport sink (input valid, byte_index, packet_done, outcome, pixel_value, output ready);
endinterface

[design/nibble_packet_framebuffer_engine_unit.sv]
// Nibble packet frame-buffer engine. Nibbles arrive low nibble first and build 7-byte
// packets (type, x, y, RGB565 colour, little-endian); every transaction on inp yields
// exactly one transaction on res. A nibble that does not close a packet is answered
// in the next cycle; a pixel read passes through S_READ, and the nibble that closes
// a packet through S_EXEC, before the result is registered. When that packet fills
// the store, inp stays not ready while the sweep runs. The frame store is one
// single-port synchronous RAM written one pixel per cycle, which sets the fill time.
// After reset the same sweep clears the store to zero before inp becomes ready;
// configuration writes are taken at any time.
`include "assert_macros.svh"

module nibble_packet_framebuffer_engine_unit
    import npfe_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF,
    parameter int LINES       = LINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    npfe_in_if.sink     inp,
    npfe_out_if.source  res
);

    localparam int DEPTH = LINE_PIXELS * LINES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {S_FILL, S_IDLE, S_READ, S_EXEC} state_t;

    state_t      state_reg;
    logic [3:0]  nibble_count_reg;
    logic [AW-1:0] sweep_reg;
    logic [15:0] fill_value_reg;
    logic        rd_ok_reg;
    logic [9:0]  active_width_reg;
    logic [8:0]  active_height_reg;

    logic        out_valid_reg;
    logic [2:0]  byte_index_reg;
    logic        done_reg;
    outcome_t    outcome_reg;
    logic [15:0] pixel_reg;

    logic [7:0]  packet_bytes [7];

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;
    logic [AW-1:0] mem_addr;
    logic        mem_we;
    logic [15:0] mem_wdata;

    // ---------------- configuration port
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_ACTIVE_WIDTH:  prdata = {22'd0, active_width_reg};
            REG_ACTIVE_HEIGHT: prdata = {23'd0, active_height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= ACTIVE_WIDTH_RST;
            active_height_reg <= ACTIVE_HEIGHT_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_ACTIVE_WIDTH:  active_width_reg  <= pwdata[9:0];
                REG_ACTIVE_HEIGHT: active_height_reg <= pwdata[8:0];
                default:           ;
            endcase
        end
    end

    // ---------------- input side
    logic       accept;
    logic [3:0] count_eff;
    logic [2:0] slot;
    logic       closing_nibble;

    assign inp.ready = (state_reg == S_IDLE) && (!out_valid_reg || res.ready);
    assign accept    = inp.valid && inp.ready;
    assign count_eff = (nibble_count_reg >= NIBBLES_PER_PACKET) ? 4'd0 : nibble_count_reg;
    assign slot      = count_eff[3:1];
    assign closing_nibble = !inp.action && (count_eff == LAST_NIBBLE);

    always_ff @(posedge clk)
    begin
        if (accept && !inp.action)
        begin
            if (!count_eff[0])
                packet_bytes[slot] <= {4'd0, inp.nibble};
            else
                packet_bytes[slot] <= {inp.nibble, packet_bytes[slot][3:0]};
        end
    end

    // ---------------- packet decode
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] colour;
    logic        pix_ok;
    logic [31:0] pix_lin;
    logic [31:0] rd_lin;
    logic        rd_ok;
    outcome_t    exec_outcome;
    logic        exec_fill;
    logic [15:0] exec_colour;

    assign px     = {packet_bytes[2], packet_bytes[1]};
    assign py     = {packet_bytes[4], packet_bytes[3]};
    assign colour = {packet_bytes[6], packet_bytes[5]};
    assign pix_ok = (px < {6'd0, active_width_reg}) && (py < {7'd0, active_height_reg})
                    && (32'(px) < 32'(LINE_PIXELS)) && (32'(py) < 32'(LINES));
    assign pix_lin = 32'(py) * 32'(LINE_PIXELS) + 32'(px);
    assign rd_lin  = 32'(inp.read_y) * 32'(LINE_PIXELS) + 32'(inp.read_x);
    assign rd_ok   = (32'(inp.read_x) < 32'(LINE_PIXELS)) && (32'(inp.read_y) < 32'(LINES));

    always_comb
    begin
        exec_fill    = 1'b0;
        exec_colour  = COLOUR_BLACK;
        exec_outcome = OUT_UNKNOWN;
        case (packet_bytes[0])
            PKT_BLANK:
            begin
                exec_fill    = 1'b1;
                exec_outcome = OUT_BLANKED;
            end
            PKT_PIXEL: exec_outcome = pix_ok ? OUT_WRITTEN : OUT_RANGE;
            PKT_RED:
            begin
                exec_fill    = 1'b1;
                exec_colour  = COLOUR_RED;
                exec_outcome = OUT_FILLED;
            end
            PKT_GREEN:
            begin
                exec_fill    = 1'b1;
                exec_colour  = COLOUR_GREEN;
                exec_outcome = OUT_FILLED;
            end
            PKT_BLUE:
            begin
                exec_fill    = 1'b1;
                exec_colour  = COLOUR_BLUE;
                exec_outcome = OUT_FILLED;
            end
            PKT_WHITE:
            begin
                exec_fill    = 1'b1;
                exec_colour  = COLOUR_WHITE;
                exec_outcome = OUT_FILLED;
            end
            PKT_FILL:
            begin
                exec_fill    = 1'b1;
                exec_colour  = colour;
                exec_outcome = OUT_FILLED;
            end
            default: exec_outcome = OUT_UNKNOWN;
        endcase
    end

    // ---------------- frame store
    always_comb
    begin
        mem_addr  = rd_lin[AW-1:0];
        mem_we    = 1'b0;
        mem_wdata = colour;
        case (state_reg)
            S_FILL:
            begin
                mem_addr  = sweep_reg;
                mem_we    = 1'b1;
                mem_wdata = fill_value_reg;
            end
            S_EXEC:
            begin
                mem_addr = pix_lin[AW-1:0];
                mem_we   = (packet_bytes[0] == PKT_PIXEL) && pix_ok;
            end
            default: mem_addr = rd_lin[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    // ---------------- control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FILL;
            nibble_count_reg <= '0;
            sweep_reg        <= '0;
            fill_value_reg   <= COLOUR_BLACK;
            rd_ok_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            byte_index_reg   <= '0;
            done_reg         <= 1'b0;
            outcome_reg      <= OUT_NONE;
            pixel_reg        <= '0;
        end
        else
        begin
            if (res.valid && res.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_FILL:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        byte_index_reg <= slot;
                        done_reg       <= 1'b0;
                        outcome_reg    <= OUT_NONE;
                        pixel_reg      <= '0;
                        if (inp.action)
                        begin
                            rd_ok_reg <= rd_ok;
                            state_reg <= S_READ;
                        end
                        else if (closing_nibble)
                        begin
                            nibble_count_reg <= '0;
                            state_reg        <= S_EXEC;
                        end
                        else
                        begin
                            nibble_count_reg <= count_eff + 4'd1;
                            out_valid_reg    <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    pixel_reg     <= rd_ok_reg ? rdata_reg : 16'd0;
                    state_reg     <= S_IDLE;
                end
                S_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    done_reg      <= 1'b1;
                    outcome_reg   <= exec_outcome;
                    if (exec_fill)
                    begin
                        fill_value_reg <= exec_colour;
                        sweep_reg      <= '0;
                        state_reg      <= S_FILL;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.byte_index  = byte_index_reg;
    assign res.packet_done = done_reg;
    assign res.outcome     = outcome_reg;
    assign res.pixel_value = pixel_reg;

    // ---------------- checks
    `ASSERT_NEXT(a_read_slot_free, clk, rst_n, accept && inp.action, !out_valid_reg)
    `ASSERT_NEXT(a_last_nibble_exec, clk, rst_n, accept && closing_nibble, state_reg == S_EXEC)
    `ASSERT_IMP(a_done_last_byte, clk, rst_n, res.valid && res.packet_done, res.byte_index == 3'd6)
    `ASSERT_IMP(a_write_when_busy, clk, rst_n, mem_we, !inp.ready)

endmodule
